// ----- rtl/mck_pkg.sv -----
// ----------------------------------------------------------------------------
// mck_pkg
// shared types, constants and the morse code table of the character keyer
// ----------------------------------------------------------------------------
package mck_pkg;

    localparam int CHAR_W     = 8;
    localparam int DOT_W      = 11;
    localparam int DUR_W      = 13;
    localparam int LEN_W      = 3;
    localparam int PAT_W      = 7;
    localparam int CNT_W      = 4;
    localparam int DOTS_W     = 3;
    localparam int PROD_W     = DOT_W + DOTS_W;
    localparam int TABLE_N    = 65;
    localparam int IDX_W      = 7;
    localparam int QUEUE_AW   = 1;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

    localparam logic [DOT_W-1:0]  DOT_RESET  = DOT_W'(240);
    localparam logic [DUR_W-1:0]  DUR_MAX    = '1;
    localparam logic [CHAR_W-1:0] CH_FIRST   = 8'd32;
    localparam logic [CHAR_W-1:0] CH_LAST    = 8'd96;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [CHAR_W-1:0] CH_OPEN    = 8'd60;
    localparam logic [CHAR_W-1:0] CH_CLOSE   = 8'd62;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'd122;
    localparam logic [CHAR_W-1:0] CASE_FOLD  = 8'd32;

    localparam logic [DOTS_W-1:0] DOTS_DOT      = 3'd1;
    localparam logic [DOTS_W-1:0] DOTS_DASH     = 3'd3;
    localparam logic [DOTS_W-1:0] DOTS_GAP      = 3'd2;
    localparam logic [DOTS_W-1:0] DOTS_WORD     = 3'd4;
    localparam logic [DOTS_W-1:0] DOTS_WORD_PRO = 3'd6;

    typedef enum logic [1:0] {
        K_LETTER,
        K_SPACE,
        K_CLOSE,
        K_BAD
    } t_kind;

    // one queued command, already classified
    typedef struct packed {
        t_kind              kind;
        logic               prosign;
        logic [LEN_W-1:0]   len;
        logic [PAT_W-1:0]   pattern;
        logic [CNT_W-1:0]   count;
    } t_cmd;

    // element count per code, 32..96
    localparam logic [LEN_W-1:0] CODE_LEN [TABLE_N] = '{
        3'd0, 3'd6, 3'd6, 3'd0, 3'd7, 3'd0, 3'd5, 3'd6,
        3'd5, 3'd6, 3'd0, 3'd5, 3'd6, 3'd5, 3'd6, 3'd5,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
        3'd5, 3'd5, 3'd6, 3'd6, 3'd0, 3'd5, 3'd0, 3'd6,
        3'd6, 3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3,
        3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3,
        3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3,
        3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd0, 3'd6,
        3'd6
    };

    // dash pattern, first element in the highest used bit
    localparam logic [PAT_W-1:0] CODE_PAT [TABLE_N] = '{
        7'd0,  7'd43, 7'd18, 7'd0,  7'd9,  7'd0,  7'd8,  7'd30,
        7'd22, 7'd45, 7'd0,  7'd10, 7'd51, 7'd17, 7'd21, 7'd18,
        7'd31, 7'd15, 7'd7,  7'd3,  7'd1,  7'd0,  7'd16, 7'd24,
        7'd28, 7'd30, 7'd56, 7'd42, 7'd0,  7'd17, 7'd0,  7'd12,
        7'd26, 7'd1,  7'd8,  7'd10, 7'd4,  7'd0,  7'd2,  7'd6,
        7'd0,  7'd0,  7'd7,  7'd5,  7'd4,  7'd3,  7'd2,  7'd7,
        7'd6,  7'd13, 7'd2,  7'd0,  7'd1,  7'd1,  7'd1,  7'd3,
        7'd9,  7'd11, 7'd12, 7'd22, 7'd18, 7'd45, 7'd0,  7'd13,
        7'd30
    };

endpackage

// ----- rtl/mck_front.sv -----
// ----------------------------------------------------------------------------
// mck_front
// accepts character items, folds case, classifies them and queues commands
// ----------------------------------------------------------------------------
module mck_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [mck_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output mck_pkg::t_cmd               o_q_cmd
);

    logic                           r_prosign;
    logic                           n_prosign;
    logic                           accept;
    logic [mck_pkg::CHAR_W-1:0]     ch;
    logic [mck_pkg::IDX_W-1:0]      idx;
    logic [mck_pkg::LEN_W-1:0]      len;
    logic [mck_pkg::CNT_W-1:0]      two_len;
    logic                           in_table;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        if (i_char_code >= mck_pkg::CH_LOWER_A && i_char_code <= mck_pkg::CH_LOWER_Z) begin
            ch = i_char_code - mck_pkg::CASE_FOLD;
        end else begin
            ch = i_char_code;
        end
    end

    assign in_table = (ch >= mck_pkg::CH_FIRST) && (ch <= mck_pkg::CH_LAST);
    assign idx      = mck_pkg::IDX_W'(ch - mck_pkg::CH_FIRST);
    assign len      = in_table ? mck_pkg::CODE_LEN[idx] : '0;
    assign two_len  = {len, 1'b0};

    always_comb begin
        n_prosign         = r_prosign;
        o_q_push          = 1'b0;
        o_q_cmd.kind      = mck_pkg::K_LETTER;
        o_q_cmd.prosign   = r_prosign;
        o_q_cmd.len       = len;
        o_q_cmd.pattern   = in_table ? mck_pkg::CODE_PAT[idx] : '0;
        o_q_cmd.count     = r_prosign ? two_len : two_len + 1'b1;
        priority if (!in_table) begin
            o_q_cmd.kind  = mck_pkg::K_BAD;
            o_q_cmd.count = mck_pkg::CNT_W'(1);
            o_q_push      = accept;
        end else if (ch == mck_pkg::CH_OPEN) begin
            // prosign entry only changes the spacing and queues nothing
            n_prosign     = accept ? 1'b1 : r_prosign;
        end else if (ch == mck_pkg::CH_CLOSE) begin
            o_q_cmd.kind  = mck_pkg::K_CLOSE;
            o_q_cmd.count = r_prosign ? mck_pkg::CNT_W'(1) : '0;
            o_q_push      = accept;
            n_prosign     = accept ? 1'b0 : r_prosign;
        end else if (ch == mck_pkg::CH_SPACE) begin
            o_q_cmd.kind  = mck_pkg::K_SPACE;
            o_q_cmd.count = mck_pkg::CNT_W'(1);
            o_q_push      = accept;
        end else begin
            o_q_push      = accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prosign <= 1'b0;
        end else begin
            r_prosign <= n_prosign;
        end
    end

endmodule

// ----- rtl/mck_queue.sv -----
// ----------------------------------------------------------------------------
// mck_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module mck_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mck_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output mck_pkg::t_cmd   o_cmd,
    output logic            o_full,
    output logic            o_empty
);

    mck_pkg::t_cmd                  r_mem [mck_pkg::QUEUE_DEPTH];
    logic [mck_pkg::QUEUE_AW-1:0]   r_wr;
    logic [mck_pkg::QUEUE_AW-1:0]   r_rd;
    logic [mck_pkg::QUEUE_AW:0]     r_cnt;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_cnt == (mck_pkg::QUEUE_AW+1)'(mck_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (mck_pkg::QUEUE_AW+1)'(do_push)
                           - (mck_pkg::QUEUE_AW+1)'(do_pop);
        end
    end

endmodule

// ----- rtl/mck_back.sv -----
// ----------------------------------------------------------------------------
// mck_back
// steps through a queued command and emits one key segment per cycle while the output is not stalled
// ----------------------------------------------------------------------------
module mck_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [mck_pkg::DOT_W-1:0]   i_dot_time,
    input  mck_pkg::t_cmd               i_q_cmd,
    input  logic                        i_q_empty,
    output logic                        o_q_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_key_on,
    output logic [mck_pkg::DUR_W-1:0]   o_duration_ms,
    output logic                        o_bad_char,
    output logic                        o_last
);

    logic                           r_busy;
    mck_pkg::t_cmd                  r_cmd;
    logic [mck_pkg::CNT_W-1:0]      r_step;
    logic                           r_out_valid;
    logic                           r_key_on;
    logic [mck_pkg::DUR_W-1:0]      r_duration;
    logic                           r_bad;
    logic                           r_last;

    logic                           slot_free;
    logic                           advance;
    logic                           drop;
    logic [mck_pkg::CNT_W-1:0]      two_len;
    logic [mck_pkg::LEN_W-1:0]      elem;
    logic [mck_pkg::LEN_W-1:0]      bit_sel;
    logic                           is_gap;
    logic                           seg_on;
    logic [mck_pkg::DOTS_W-1:0]     dots;
    logic [mck_pkg::PROD_W-1:0]     prod;
    logic [mck_pkg::DUR_W-1:0]      dur;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign advance   = r_busy && slot_free;
    assign o_q_pop   = !r_busy && !i_q_empty;
    // nothing to send when the command has no segments or the dot time is zero
    assign drop      = (i_q_cmd.count == '0)
                    || (i_q_cmd.kind != mck_pkg::K_BAD && i_dot_time == '0);

    assign two_len = {r_cmd.len, 1'b0};
    assign elem    = r_step[mck_pkg::CNT_W-1:1];
    assign bit_sel = r_cmd.len - 1'b1 - elem;
    assign is_gap  = (r_step == two_len);

    always_comb begin
        seg_on = 1'b0;
        unique case (r_cmd.kind)
            mck_pkg::K_LETTER: begin
                seg_on = !is_gap && !r_step[0];
                if (is_gap) begin
                    dots = mck_pkg::DOTS_GAP;
                end else if (r_step[0]) begin
                    dots = mck_pkg::DOTS_DOT;
                end else begin
                    dots = r_cmd.pattern[bit_sel] ? mck_pkg::DOTS_DASH : mck_pkg::DOTS_DOT;
                end
            end
            mck_pkg::K_SPACE: begin
                dots = r_cmd.prosign ? mck_pkg::DOTS_WORD_PRO : mck_pkg::DOTS_WORD;
            end
            mck_pkg::K_CLOSE: begin
                dots = mck_pkg::DOTS_GAP;
            end
            mck_pkg::K_BAD: begin
                dots = '0;
            end
        endcase
    end

    assign prod = mck_pkg::PROD_W'(dots) * mck_pkg::PROD_W'(i_dot_time);
    assign dur  = (prod > mck_pkg::PROD_W'(mck_pkg::DUR_MAX)) ? mck_pkg::DUR_MAX
                                                               : prod[mck_pkg::DUR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_cmd  <= i_q_cmd;
                r_step <= '0;
                r_busy <= !drop;
            end else if (advance) begin
                r_step <= r_step + 1'b1;
                if (r_step == r_cmd.count - 1'b1) begin
                    r_busy <= 1'b0;
                end
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_key_on    <= seg_on;
                r_duration  <= dur;
                r_bad       <= (r_cmd.kind == mck_pkg::K_BAD);
                r_last      <= (r_step == r_cmd.count - 1'b1);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_key_on      = r_key_on;
    assign o_duration_ms = r_duration;
    assign o_bad_char    = r_bad;
    assign o_last        = r_last;

endmodule

// ----- rtl/morse_character_keyer_top.sv -----
// ----------------------------------------------------------------------------
// morse_character_keyer_top
// morse keyer: turns character items into timed key segments
// ----------------------------------------------------------------------------
// input channel: i_in_valid / o_in_stall carry one character byte per item;
// lower case is folded, unknown bytes give one result flagged bad_char.
// output channel: o_out_valid / i_out_stall carry one key segment per item,
// key level plus length in ms, with last set on the final segment of a
// character. '<' gives no segments and only switches to prosign spacing.
// config: i_cfg_valid / o_cfg_ready write the dot time in ms; ready is
// always high, and writes belong to idle periods.
// timing: a taken character is written into the command queue, popped into
// the back end, and the segment sequencer there registers its segments at
// the output one after another, holding while i_out_stall is set.
// a two-entry command queue lets the front take further characters while
// the back is busy or held by i_out_stall; a held segment stays unchanged.
// reset clears the queue, the output register and prosign mode, and
// reloads the dot time with 240 ms.
// ----------------------------------------------------------------------------
module morse_character_keyer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [mck_pkg::CHAR_W-1:0]  i_char_code,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_key_on,
    output logic [mck_pkg::DUR_W-1:0]   o_duration_ms,
    output logic                        o_bad_char,
    output logic                        o_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mck_pkg::DOT_W-1:0]   i_cfg_dot_time_ms
);

    logic [mck_pkg::DOT_W-1:0]  r_dot_time;
    logic                       q_push;
    logic                       q_pop;
    logic                       q_full;
    logic                       q_empty;
    mck_pkg::t_cmd              q_in;
    mck_pkg::t_cmd              q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_time <= mck_pkg::DOT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dot_time <= i_cfg_dot_time_ms;
        end
    end

    mck_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_char_code (i_char_code),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in)
    );

    mck_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mck_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dot_time    (r_dot_time),
        .i_q_cmd       (q_out),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_key_on      (o_key_on),
        .o_duration_ms (o_duration_ms),
        .o_bad_char    (o_bad_char),
        .o_last        (o_last)
    );

endmodule

// ----- rtl/mck_checker.sv -----
// ----------------------------------------------------------------------------
// mck_checker
// port-level checks on the keyer output stream
// ----------------------------------------------------------------------------
module mck_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  logic                        o_key_on,
    input  logic [mck_pkg::DUR_W-1:0]   o_duration_ms,
    input  logic                        o_bad_char,
    input  logic                        o_last
);

    // a held segment keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_duration_ms)
            && $stable(o_key_on) && $stable(o_last) && $stable(o_bad_char))
        else $error("output segment changed while stalled");

    // a bad character item is a single empty key-up result
    a_bad_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_char |-> o_last && !o_key_on && o_duration_ms == '0)
        else $error("malformed bad character result");

    // real segments always have a length
    a_dur_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_bad_char |-> o_duration_ms != '0)
        else $error("zero length segment emitted");

    // every character ends with the key up
    a_last_key_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> !o_key_on)
        else $error("character ended with key down");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

endmodule

bind morse_character_keyer_top mck_checker u_mck_checker (.*);

// ----- tb/morse_character_keyer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// morse character keyer testbench
// drives character items through the keyer and checks every key segment
// against a cycle-free model of the morse encoding, under several dot times
// and with random idling on both channels
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 64;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_REPORTS     = 10;
    localparam int N_PHASES        = 9;
    localparam int ITEMS_PER_PHASE = 42;
    localparam int DIR_MAX         = 32;
    localparam int SEG_MAX_MS      = 8191;

    localparam int CW  = mck_pkg::CHAR_W;
    localparam int DW  = mck_pkg::DOT_W;
    localparam int MSW = mck_pkg::DUR_W;

    localparam logic [CW-1:0] C_SPACE     = 8'h20;
    localparam logic [CW-1:0] C_OPEN      = 8'h3C;
    localparam logic [CW-1:0] C_CLOSE     = 8'h3E;
    localparam logic [CW-1:0] C_TBL_FIRST = 8'h20;
    localparam logic [CW-1:0] C_TBL_LAST  = 8'h60;
    localparam logic [CW-1:0] C_LOWER_A   = 8'h61;
    localparam logic [CW-1:0] C_LOWER_Z   = 8'h7A;
    localparam logic [CW-1:0] C_FOLD      = 8'h20;
    localparam logic [DW-1:0] DOT_AT_RESET = 11'd240;

    // dot times of the random phases, later ones are drawn at random
    localparam int DOT_PLAN [0:5] = '{1, 2047, 0, 10, 1200, 3};

    // element count and dash mask per code 32..96, first element highest
    localparam logic [2:0] ELEM_COUNT [0:64] = '{
        3'd0, 3'd6, 3'd6, 3'd0, 3'd7, 3'd0, 3'd5, 3'd6,
        3'd5, 3'd6, 3'd0, 3'd5, 3'd6, 3'd5, 3'd6, 3'd5,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
        3'd5, 3'd5, 3'd6, 3'd6, 3'd0, 3'd5, 3'd0, 3'd6,
        3'd6, 3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3,
        3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3,
        3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3,
        3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd0, 3'd6,
        3'd6
    };
    localparam logic [6:0] DASH_BITS [0:64] = '{
        7'd0,  7'd43, 7'd18, 7'd0,  7'd9,  7'd0,  7'd8,  7'd30,
        7'd22, 7'd45, 7'd0,  7'd10, 7'd51, 7'd17, 7'd21, 7'd18,
        7'd31, 7'd15, 7'd7,  7'd3,  7'd1,  7'd0,  7'd16, 7'd24,
        7'd28, 7'd30, 7'd56, 7'd42, 7'd0,  7'd17, 7'd0,  7'd12,
        7'd26, 7'd1,  7'd8,  7'd10, 7'd4,  7'd0,  7'd2,  7'd6,
        7'd0,  7'd0,  7'd7,  7'd5,  7'd4,  7'd3,  7'd2,  7'd7,
        7'd6,  7'd13, 7'd2,  7'd0,  7'd1,  7'd1,  7'd1,  7'd3,
        7'd9,  7'd11, 7'd12, 7'd22, 7'd18, 7'd45, 7'd0,  7'd13,
        7'd30
    };

    typedef struct packed {
        logic           key_on;
        logic [MSW-1:0] duration_ms;
        logic           bad_char;
        logic           last;
    } t_seg;

    localparam t_seg SEG_NONE = '0;

    typedef enum logic [1:0] {
        PACE_SLOW_SINK,
        PACE_SLOW_SOURCE,
        PACE_FULL
    } t_pace;

    logic            i_clk             = 1'b0;
    logic            i_rst_n           = 1'b0;
    logic            i_in_valid        = 1'b0;
    logic [CW-1:0]   i_char_code       = '0;
    logic            i_out_stall       = 1'b0;
    logic            i_cfg_valid       = 1'b0;
    logic [DW-1:0]   i_cfg_dot_time_ms = '0;
    logic            o_in_stall;
    logic            o_out_valid;
    logic            o_key_on;
    logic [MSW-1:0]  o_duration_ms;
    logic            o_bad_char;
    logic            o_last;
    logic            o_cfg_ready;

    // keyer state as the testbench sees it
    logic            prosign_q = 1'b0;
    logic [DW-1:0]   dot_ms    = DOT_AT_RESET;

    t_seg            pred_segs [$];
    t_seg            segs_due  [$];
    int              mismatches = 0;
    int              cycle_cnt  = 0;
    int              in_idle_pct  = 0;
    int              out_idle_pct = 0;

    logic [CW-1:0]   dir_code    [DIR_MAX];
    int              dir_typed_n [DIR_MAX];
    t_seg            dir_seg     [DIR_MAX][3];
    int              n_dir = 0;

    morse_character_keyer_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_char_code       (i_char_code),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_key_on          (o_key_on),
        .o_duration_ms     (o_duration_ms),
        .o_bad_char        (o_bad_char),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_dot_time_ms (i_cfg_dot_time_ms)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_seg mk_seg(input logic key, input int unsigned ms,
                                    input logic bad, input logic last);
        t_seg s;
        s.key_on      = key;
        s.duration_ms = ms[MSW-1:0];
        s.bad_char    = bad;
        s.last        = last;
        return s;
    endfunction

    task automatic push_key(input logic key, input int unsigned dots);
        int unsigned ms;
        ms = dots * int'(dot_ms);
        if (ms == 0) begin
            return;
        end
        if (ms > SEG_MAX_MS) begin
            ms = SEG_MAX_MS;
        end
        pred_segs.push_back(mk_seg(key, ms, 1'b0, 1'b0));
    endtask

    // segments that one character should give, updates prosign state
    task automatic keyer_predict(input logic [CW-1:0] raw);
        logic [CW-1:0] c;
        int unsigned   gap;
        int            idx;
        int            n_el;
        logic [6:0]    dashes;
        t_seg          tail;
        c   = raw;
        gap = prosign_q ? 1 : 3;
        pred_segs.delete();
        if (c >= C_LOWER_A && c <= C_LOWER_Z) begin
            c = c - C_FOLD;
        end
        if (c < C_TBL_FIRST || c > C_TBL_LAST) begin
            pred_segs.push_back(mk_seg(1'b0, 0, 1'b1, 1'b1));
            return;
        end
        if (c == C_SPACE) begin
            push_key(1'b0, 7 - gap);
        end else if (c == C_OPEN) begin
            prosign_q = 1'b1;
        end else if (c == C_CLOSE) begin
            push_key(1'b0, 3 - gap);
            prosign_q = 1'b0;
        end else begin
            idx    = int'(c - C_TBL_FIRST);
            n_el   = int'(ELEM_COUNT[idx]);
            dashes = DASH_BITS[idx];
            for (int i = n_el - 1; i >= 0; i--) begin
                push_key(1'b1, dashes[i] ? 3 : 1);
                push_key(1'b0, 1);
            end
            push_key(1'b0, gap - 1);
        end
        if (pred_segs.size() > 0) begin
            tail = pred_segs.pop_back();
            tail.last = 1'b1;
            pred_segs.push_back(tail);
        end
    endtask

    task automatic add_row(input logic [CW-1:0] code, input int n,
                           input t_seg s0, input t_seg s1, input t_seg s2);
        dir_code[n_dir]    = code;
        dir_typed_n[n_dir] = n;
        dir_seg[n_dir][0]  = s0;
        dir_seg[n_dir][1]  = s1;
        dir_seg[n_dir][2]  = s2;
        n_dir++;
    endtask

    task automatic set_pace(input t_pace pace);
        case (pace)
            PACE_SLOW_SINK: begin
                in_idle_pct  = 38;
                out_idle_pct = 80;
            end
            PACE_SLOW_SOURCE: begin
                in_idle_pct  = 80;
                out_idle_pct = 38;
            end
            default: begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
        endcase
    endtask

    // row < 0 or a row with a negative count: expectations come from the model, else from the directed table
    task automatic send_char(input logic [CW-1:0] c, input int row);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        keyer_predict(c);
        if (row < 0 || dir_typed_n[row] < 0) begin
            foreach (pred_segs[k]) begin
                segs_due.push_back(pred_segs[k]);
            end
        end else begin
            for (int k = 0; k < dir_typed_n[row]; k++) begin
                segs_due.push_back(dir_seg[row][k]);
            end
        end
    endtask

    task automatic write_dot(input logic [DW-1:0] v);
        i_cfg_valid       <= 1'b1;
        i_cfg_dot_time_ms <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        dot_ms = v;
    endtask

    // let the keyer run dry, including items that give no segment
    task automatic finish_phase();
        i_in_valid <= 1'b0;
        while (segs_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CW-1:0] rand_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            return CW'($urandom_range(0, 31));
        end else if (r < 9) begin
            return CW'($urandom_range(123, 255));
        end else if (r < 15) begin
            return C_OPEN;
        end else if (r < 21) begin
            return C_CLOSE;
        end else if (r < 29) begin
            return C_SPACE;
        end else if (r < 60) begin
            return CW'($urandom_range(97, 122));
        end
        return CW'($urandom_range(33, 96));
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end

    always @(posedge i_clk) begin
        t_seg got;
        t_seg want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = mk_seg(o_key_on, 32'(o_duration_ms), o_bad_char, o_last);
            if (segs_due.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("unexpected segment: key %0d ms %0d bad %0d last %0d",
                             got.key_on, got.duration_ms, got.bad_char, got.last);
                end
                mismatches++;
            end else begin
                want = segs_due.pop_front();
                if (got.key_on !== want.key_on || got.duration_ms !== want.duration_ms
                        || got.bad_char !== want.bad_char || got.last !== want.last) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("segment mismatch: want key %0d ms %0d bad %0d last %0d",
                                 want.key_on, want.duration_ms, want.bad_char, want.last);
                        $display("                   got key %0d ms %0d bad %0d last %0d",
                                 got.key_on, got.duration_ms, got.bad_char, got.last);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int v;
        // error codes and reset-time characters are written out, the rest predicted
        add_row(8'h00, 1, mk_seg(1'b0, 0, 1'b1, 1'b1), SEG_NONE, SEG_NONE);
        add_row(8'hFF, 1, mk_seg(1'b0, 0, 1'b1, 1'b1), SEG_NONE, SEG_NONE);
        add_row(8'h80, 1, mk_seg(1'b0, 0, 1'b1, 1'b1), SEG_NONE, SEG_NONE);
        add_row(8'h1F, 1, mk_seg(1'b0, 0, 1'b1, 1'b1), SEG_NONE, SEG_NONE);
        add_row(8'h7F, 1, mk_seg(1'b0, 0, 1'b1, 1'b1), SEG_NONE, SEG_NONE);
        add_row(8'h7B, 1, mk_seg(1'b0, 0, 1'b1, 1'b1), SEG_NONE, SEG_NONE);
        add_row("a", -1, SEG_NONE, SEG_NONE, SEG_NONE);
        add_row("z", -1, SEG_NONE, SEG_NONE, SEG_NONE);
        add_row("E", 3, mk_seg(1'b1, 240, 1'b0, 1'b0), mk_seg(1'b0, 240, 1'b0, 1'b0),
                mk_seg(1'b0, 480, 1'b0, 1'b1));
        add_row("T", 3, mk_seg(1'b1, 720, 1'b0, 1'b0), mk_seg(1'b0, 240, 1'b0, 1'b0),
                mk_seg(1'b0, 480, 1'b0, 1'b1));
        // empty code, only the letter gap
        add_row("#", 1, mk_seg(1'b0, 480, 1'b0, 1'b1), SEG_NONE, SEG_NONE);
        add_row(C_SPACE, 1, mk_seg(1'b0, 960, 1'b0, 1'b1), SEG_NONE, SEG_NONE);
        // close angle outside prosign mode gives nothing
        add_row(C_CLOSE, 0, SEG_NONE, SEG_NONE, SEG_NONE);
        add_row("0", -1, SEG_NONE, SEG_NONE, SEG_NONE);
        add_row("9", -1, SEG_NONE, SEG_NONE, SEG_NONE);
        add_row(",", -1, SEG_NONE, SEG_NONE, SEG_NONE);
        add_row("?", -1, SEG_NONE, SEG_NONE, SEG_NONE);
        add_row("$", -1, SEG_NONE, SEG_NONE, SEG_NONE);
        add_row(8'h60, -1, SEG_NONE, SEG_NONE, SEG_NONE);
        add_row(C_OPEN, 0, SEG_NONE, SEG_NONE, SEG_NONE);
        add_row("S", -1, SEG_NONE, SEG_NONE, SEG_NONE);
        add_row(C_SPACE, -1, SEG_NONE, SEG_NONE, SEG_NONE);
        add_row(C_CLOSE, -1, SEG_NONE, SEG_NONE, SEG_NONE);
        add_row("^", -1, SEG_NONE, SEG_NONE, SEG_NONE);
        add_row("@", -1, SEG_NONE, SEG_NONE, SEG_NONE);

        set_pace(PACE_SLOW_SINK);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < n_dir; r++) begin
            send_char(dir_code[r], r);
        end
        finish_phase();

        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 3) begin
                set_pace(PACE_SLOW_SOURCE);
            end else if (p == 6) begin
                set_pace(PACE_FULL);
            end
            v = (p < 6) ? DOT_PLAN[p] : int'($urandom_range(10, 1200));
            write_dot(v[DW-1:0]);
            repeat (ITEMS_PER_PHASE) send_char(rand_char(), -1);
            finish_phase();
        end

        if (mismatches == 0 && segs_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
